// ----- rtl/idr_pkg.sv -----
// ----------------------------------------------------------------------------
// idr_pkg
// Shared types, constants and the sine table of the dead reckoning step.
// ----------------------------------------------------------------------------
package idr_pkg;

   localparam int TRIG_FRAC_BITS = 15;
   localparam int ACCUM_BITS     = 48;

   // sequencer states, one-hot
   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_TRIG   = 11'b000_0000_0010,
      ST_MUL_A  = 11'b000_0000_0100,
      ST_MUL_B  = 11'b000_0000_1000,
      ST_MUL_DV = 11'b000_0001_0000,
      ST_MUL_V  = 11'b000_0010_0000,
      ST_DIV_V  = 11'b000_0100_0000,
      ST_MUL_P  = 11'b000_1000_0000,
      ST_DIV_P  = 11'b001_0000_0000,
      ST_DONE   = 11'b010_0000_0000,
      ST_OUT    = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      state_type phase;
      logic      load;
      logic      step;
      logic      take;
   } lane_ctl_type;

   // cycle index of the result take in a multiply or divide state
   localparam logic [5:0] MUL_LAST = 6'd21;
   localparam logic [5:0] DIV_LAST = 6'd48;

   // halved divisors and rounding offsets of the unit conversions
   localparam logic [10:0] DIVH_V = 11'd500;
   localparam logic [46:0] RND_V  = 47'd250;
   localparam logic [10:0] DIVH_P = 11'd1000;
   localparam logic [46:0] RND_P  = 47'd500;

   localparam logic [63:0] PI_Q40 = 64'h0000_0324_3F6A_8886;

   typedef logic [63:0] taylor_den_type [1:9];
   localparam taylor_den_type TAYLOR_DEN = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                            64'd156, 64'd210, 64'd272, 64'd342};

   typedef logic [15:0] trig_tab_type [0:90];

   // Taylor series of sin in Q30, clamped and rounded to TRIG_FRAC_BITS
   function automatic trig_tab_type build_trig_tab();
      trig_tab_type tab;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      longint       s;
      for (int d = 0; d <= 90; d++) begin
         x  = ((64'(d) * PI_Q40) / 64'd180 + 64'd512) >> 10;
         x2 = (x * x + (64'd1 << 29)) >> 30;
         t  = x;
         s  = longint'(x);
         for (int k = 1; k <= 9; k++) begin
            t = ((t * x2) >> 30) / TAYLOR_DEN[k];
            if ((k % 2) == 1) begin
               s = s - longint'(t);
            end else begin
               s = s + longint'(t);
            end
         end
         if (s < 0) s = 0;
         if (s > (longint'(1) << 30)) s = longint'(1) << 30;
         tab[d] = 16'((s + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS));
      end
      return tab;
   endfunction

   localparam trig_tab_type TRIG_TAB = build_trig_tab();

   function automatic logic [47:0] abs48(input logic signed [47:0] v);
      return v[47] ? 48'(-v) : 48'(v);
   endfunction

   // saturated magnitude of a sign/magnitude product
   function automatic logic [47:0] sat_mag(input logic [67:0] p, input logic neg);
      if (|p[67:47]) begin
         return neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      end
      return p[47:0];
   endfunction

   function automatic logic signed [47:0] sat_add48(input logic signed [47:0] a,
                                                    input logic signed [47:0] b);
      logic signed [48:0] s;
      s = 49'(a) + 49'(b);
      if (s[48] != s[47]) begin
         return s[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
      end
      return s[47:0];
   endfunction

endpackage

// ----- rtl/idr_lane.sv -----
// ----------------------------------------------------------------------------
// idr_lane
// One world axis: rotation sum, bit-serial multiplier, bit-serial divider
// and the velocity and position accumulators.
// ----------------------------------------------------------------------------
module idr_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  idr_pkg::lane_ctl_type     ctl,
   input  logic signed [13:0]        rot_a1,
   input  logic signed [16:0]        rot_c1,
   input  logic signed [13:0]        rot_a2,
   input  logic signed [16:0]        rot_c2,
   input  logic [19:0]               dt,
   output logic signed [14:0]        accel_world,
   output logic signed [47:0]        speed,
   output logic signed [47:0]        place
);
   import idr_pkg::*;

   logic [47:0]        mcand_ff,  mcand_in;
   logic               mneg_ff,   mneg_in;
   logic [19:0]        mpl_ff,    mpl_in;
   logic [67:0]        prod_ff,   prod_in;
   logic [46:0]        num_ff,    num_in;
   logic [9:0]         rem_ff,    rem_in;
   logic [46:0]        dnum_ff;
   logic               dneg_ff;
   logic signed [30:0] rsum_ff;
   logic signed [14:0] w_ff;
   logic signed [47:0] dv_ff, q1_ff, dp_ff;
   logic signed [47:0] vel_ff, pos_ff;

   logic signed [47:0] op_a;
   logic signed [16:0] op_c;
   logic [16:0]        op_cmag;
   logic signed [30:0] rot_p;
   logic signed [30:0] wsum;
   logic [47:0]        smag;
   logic signed [47:0] sval;
   logic [46:0]        dnum_new;
   logic [10:0]        divisor;
   logic [10:0]        trial;
   logic               qbit;
   logic signed [47:0] quot;

   // pick the multiplier operands for the phase being loaded
   always_comb begin
      op_a = '0;
      op_c = 17'sd1;
      case (ctl.phase)
         ST_MUL_A:  begin op_a = 48'(rot_a1); op_c = rot_c1; end
         ST_MUL_B:  begin op_a = 48'(rot_a2); op_c = rot_c2; end
         ST_MUL_DV: op_a = 48'(w_ff);
         ST_MUL_V:  op_a = vel_ff;
         ST_MUL_P:  op_a = dv_ff;
         default:   op_a = '0;
      endcase
      op_cmag = op_c[16] ? 17'(-op_c) : 17'(op_c);
   end

   always_comb begin
      mcand_in = mcand_ff;
      mneg_in  = mneg_ff;
      mpl_in   = mpl_ff;
      prod_in  = prod_ff;
      if (ctl.load) begin
         mcand_in = abs48(op_a);
         prod_in  = '0;
         if (ctl.phase inside {ST_MUL_A, ST_MUL_B}) begin
            mneg_in = op_a[47] ^ op_c[16];
            mpl_in  = {4'b0, op_cmag[15:0]};
         end else begin
            mneg_in = op_a[47];
            mpl_in  = dt;
         end
      end else if (ctl.step) begin
         prod_in = {prod_ff[66:0], 1'b0} + (mpl_ff[19] ? {20'b0, mcand_ff} : 68'd0);
         mpl_in  = {mpl_ff[18:0], 1'b0};
      end
   end

   assign rot_p    = mneg_ff ? 31'(-prod_ff[30:0]) : 31'(prod_ff[30:0]);
   assign wsum     = rsum_ff + rot_p;
   assign smag     = sat_mag(prod_ff, mneg_ff);
   assign sval     = mneg_ff ? 48'(-smag) : 48'(smag);
   assign dnum_new = 47'(smag[47:1]) + 47'(smag[0])
                     + ((ctl.phase == ST_MUL_V) ? RND_V : RND_P);

   // restoring division, one quotient bit a cycle, quotient shifts into num
   assign divisor = (ctl.phase == ST_DIV_V) ? DIVH_V : DIVH_P;
   assign trial   = {rem_ff, num_ff[46]};
   assign qbit    = trial >= divisor;
   assign quot    = dneg_ff ? 48'(-{1'b0, num_ff}) : 48'({1'b0, num_ff});

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      if (ctl.load) begin
         num_in = dnum_ff;
         rem_in = '0;
      end else if (ctl.step) begin
         rem_in = qbit ? 10'(trial - divisor) : trial[9:0];
         num_in = {num_ff[45:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      mneg_ff  <= mneg_in;
      mpl_ff   <= mpl_in;
      prod_ff  <= prod_in;
      if (ctl.phase inside {ST_DIV_V, ST_DIV_P}) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
      if (ctl.take) begin
         case (ctl.phase)
            ST_MUL_A:  rsum_ff <= rot_p;
            ST_MUL_B:  w_ff <= 15'((wsum + 31'sd16384) >>> TRIG_FRAC_BITS);
            ST_MUL_DV: dv_ff <= sval;
            ST_MUL_V:  begin dnum_ff <= dnum_new; dneg_ff <= mneg_ff; end
            ST_DIV_V:  q1_ff <= quot;
            ST_MUL_P:  begin dnum_ff <= dnum_new; dneg_ff <= mneg_ff; end
            ST_DIV_P:  dp_ff <= sat_add48(q1_ff, quot);
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff <= '0;
         pos_ff <= '0;
      end else if (ctl.phase == ST_DONE) begin
         vel_ff <= sat_add48(vel_ff, dv_ff);
         pos_ff <= sat_add48(pos_ff, dp_ff);
      end
   end

   assign accel_world = w_ff;
   assign speed       = vel_ff;
   assign place       = pos_ff;

endmodule

// ----- rtl/inertial_dead_reckoning_step.sv -----
// ----------------------------------------------------------------------------
// inertial_dead_reckoning_step
// Planar dead reckoning: rotate body acceleration by the heading, then
// integrate world velocity and position, both axes side by side.
// ----------------------------------------------------------------------------
// Sequence: from the accepting edge an item passes a trig lookup, five serial
//   multiplies, two serial divides and an update before rsp_valid rises.
// A new item is accepted only once the previous result has left (rsp_stall holds it);
//   the 20-bit serial multiplier and the 47-bit serial divider in each lane set the pace.
// Reset (synchronous): sequencer idle, no result pending, velocity and
//   position cleared to zero.
module inertial_dead_reckoning_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [13:0] req_accel_body_x,
   input  logic signed [13:0] req_accel_body_y,
   input  logic [8:0]         req_heading_deg,
   input  logic [19:0]        req_elapsed_us,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [14:0] rsp_accel_world_x,
   output logic signed [14:0] rsp_accel_world_y,
   output logic signed [47:0] rsp_speed_x,
   output logic signed [47:0] rsp_speed_y,
   output logic signed [47:0] rsp_place_x,
   output logic signed [47:0] rsp_place_y
);
   import idr_pkg::*;

   state_type          state_ff, state_in;
   logic [5:0]         cnt_ff,   cnt_in;
   logic [5:0]         last;
   logic               busy_op;
   lane_ctl_type       ctl;

   logic signed [13:0] ax_ff, ay_ff;
   logic [8:0]         h_ff;
   logic [19:0]        dt_ff;
   logic signed [16:0] sn_ff, cs_ff;
   logic signed [16:0] sn_neg;

   logic [8:0]         hr;
   logic [6:0]         rr;
   logic [1:0]         quad;
   logic signed [16:0] sr, cr;
   logic               accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;

   // capture the item
   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff <= req_accel_body_x;
         ay_ff <= req_accel_body_y;
         h_ff  <= req_heading_deg;
         dt_ff <= req_elapsed_us;
      end
   end

   // reduce heading to a quadrant and an offset of 0..89 degrees
   always_comb begin
      hr = (h_ff >= 9'd360) ? 9'(h_ff - 9'd360) : h_ff;
      if (hr < 9'd90) begin
         quad = 2'd0; rr = 7'(hr);
      end else if (hr < 9'd180) begin
         quad = 2'd1; rr = 7'(hr - 9'd90);
      end else if (hr < 9'd270) begin
         quad = 2'd2; rr = 7'(hr - 9'd180);
      end else begin
         quad = 2'd3; rr = 7'(hr - 9'd270);
      end
      sr = 17'(TRIG_TAB[rr]);
      cr = 17'(TRIG_TAB[7'd90 - rr]);
   end

   // fold the quadrant into sine and cosine
   always_ff @(posedge clock) begin
      if (state_ff == ST_TRIG) begin
         case (quad)
            2'd0:    begin sn_ff <= sr;  cs_ff <= cr;  end
            2'd1:    begin sn_ff <= cr;  cs_ff <= -sr; end
            2'd2:    begin sn_ff <= -sr; cs_ff <= -cr; end
            default: begin sn_ff <= -cr; cs_ff <= sr;  end
         endcase
      end
   end

   assign sn_neg = -sn_ff;

   // sequencer: every multiply and divide state loads, steps, then takes
   assign busy_op = state_ff inside {ST_MUL_A, ST_MUL_B, ST_MUL_DV, ST_MUL_V,
                                     ST_DIV_V, ST_MUL_P, ST_DIV_P};
   assign last    = (state_ff inside {ST_DIV_V, ST_DIV_P}) ? DIV_LAST : MUL_LAST;

   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_TRIG;
         ST_TRIG:   state_in = ST_MUL_A;
         ST_DONE:   state_in = ST_OUT;
         ST_OUT:    if (!rsp_stall) state_in = ST_IDLE;
         ST_MUL_A, ST_MUL_B, ST_MUL_DV, ST_MUL_V, ST_DIV_V, ST_MUL_P, ST_DIV_P: begin
            if (cnt_ff == last) begin
               case (state_ff)
                  ST_MUL_A:  state_in = ST_MUL_B;
                  ST_MUL_B:  state_in = ST_MUL_DV;
                  ST_MUL_DV: state_in = ST_MUL_V;
                  ST_MUL_V:  state_in = ST_DIV_V;
                  ST_DIV_V:  state_in = ST_MUL_P;
                  ST_MUL_P:  state_in = ST_DIV_P;
                  default:   state_in = ST_DONE;
               endcase
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign ctl.phase = state_ff;
   assign ctl.load  = busy_op && (cnt_ff == 6'd0);
   assign ctl.step  = busy_op && (cnt_ff != 6'd0) && (cnt_ff != last);
   assign ctl.take  = busy_op && (cnt_ff == last);

   // x: ax*cos + ay*sin ; y: ay*cos - ax*sin
   idr_lane u_lane_x (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .rot_a1      (ax_ff),
      .rot_c1      (cs_ff),
      .rot_a2      (ay_ff),
      .rot_c2      (sn_ff),
      .dt          (dt_ff),
      .accel_world (rsp_accel_world_x),
      .speed       (rsp_speed_x),
      .place       (rsp_place_x)
   );

   idr_lane u_lane_y (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .rot_a1      (ay_ff),
      .rot_c1      (cs_ff),
      .rot_a2      (ax_ff),
      .rot_c2      (sn_neg),
      .dt          (dt_ff),
      .accel_world (rsp_accel_world_y),
      .speed       (rsp_speed_y),
      .place       (rsp_place_y)
   );

   a_accept_to_trig: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_TRIG)
      else $error("accepted item did not start the trig lookup");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= last)
      else $error("step counter ran past the last cycle of its state");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && rsp_stall |=> state_ff == ST_OUT)
      else $error("result dropped while stalled");

   a_done_to_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_valid)
      else $error("update did not present a result");

endmodule
